// ----- src/kch_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the k-mer count histogram core.
// No dependencies; imported by every other file in src but kch_table_ram.
package kch_pkg;

    localparam int MAX_WORD_LENGTH = 8;
    localparam int COUNT_BITS      = 32;
    localparam int INDEX_BITS      = 2 * MAX_WORD_LENGTH;
    localparam int WL_BITS         = 4;
    localparam int RUN_BITS        = $clog2(MAX_WORD_LENGTH + 1);
    localparam int WORD_LENGTH_RST = 4;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [INDEX_BITS-1:0] index_t;

    localparam count_t COUNT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_SYMBOL     = 2'd0,
        MODE_BREAK      = 2'd1,
        MODE_READ_COUNT = 2'd2,
        MODE_READ_TOTAL = 2'd3
    } mode_t;

    // operation carried into the read-modify-write stage
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INC,
        OP_READ_CLEAR,
        OP_TOTAL
    } op_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  symbol;
        logic        symbol_invalid;
        logic [15:0] word_index;
    } kch_in_t;

    typedef struct packed {
        logic [31:0] value;
        logic        is_total;
    } kch_out_t;

    typedef struct packed {
        op_t    op;
        index_t addr;
        count_t total;
    } kch_ctrl_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

endpackage

// ----- src/kch_table_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Generic; no package dependency.
module kch_table_ram #(
    parameter int ADDR_BITS = 16,
    parameter int DATA_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/kch_front.sv -----
`timescale 1ns / 1ps
// Front stage: sliding symbol window, valid run length, running total and the
// table address for each accepted word. Depends on kch_pkg.
module kch_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  kch_pkg::kch_in_t           in_word,
    input  logic [kch_pkg::WL_BITS-1:0] word_length,
    output kch_pkg::kch_ctrl_t         ctrl
);
    import kch_pkg::*;

    index_t                window_reg, window_next;
    logic [RUN_BITS-1:0]   run_reg, run_next;
    count_t                total_reg, total_next;
    logic [WL_BITS-1:0]    k_eff;
    index_t                k_mask;
    index_t                shifted;

    always_comb begin
        if (word_length == '0) begin
            k_eff = WL_BITS'(1);
        end else if (word_length > WL_BITS'(MAX_WORD_LENGTH)) begin
            k_eff = WL_BITS'(MAX_WORD_LENGTH);
        end else begin
            k_eff = word_length;
        end
        for (int i = 0; i < MAX_WORD_LENGTH; i++) begin
            k_mask[2*i +: 2] = (WL_BITS'(i) < k_eff) ? 2'b11 : 2'b00;
        end
    end

    // newest symbol enters as the lowest base-4 digit
    assign shifted = INDEX_BITS'({window_reg, in_word.symbol});

    always_comb begin
        window_next = window_reg;
        run_next    = run_reg;
        total_next  = total_reg;
        ctrl.op     = OP_NONE;
        ctrl.addr   = shifted & k_mask;
        ctrl.total  = total_reg;
        case (in_word.mode)
            MODE_SYMBOL: begin
                if (in_word.symbol_invalid) begin
                    window_next = '0;
                    run_next    = '0;
                end else begin
                    window_next = shifted;
                    if (run_reg < RUN_BITS'(MAX_WORD_LENGTH)) begin
                        run_next = run_reg + RUN_BITS'(1);
                    end
                    if (WL_BITS'(run_next) >= k_eff) begin
                        ctrl.op    = OP_INC;
                        total_next = sat_inc(total_reg);
                    end
                end
            end
            MODE_BREAK: begin
                window_next = '0;
                run_next    = '0;
            end
            MODE_READ_COUNT: begin
                ctrl.op   = OP_READ_CLEAR;
                ctrl.addr = in_word.word_index[INDEX_BITS-1:0];
            end
            MODE_READ_TOTAL: begin
                ctrl.op    = OP_TOTAL;
                total_next = '0;
            end
            default: begin
                ctrl.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            run_reg    <= '0;
            total_reg  <= '0;
        end else if (accept) begin
            window_reg <= window_next;
            run_reg    <= run_next;
            total_reg  <= total_next;
        end
    end

endmodule

// ----- src/kch_out_buf.sv -----
`timescale 1ns / 1ps
// Two-entry result buffer between the update stage and the m_ channel.
// Depends on kch_pkg.
module kch_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  kch_pkg::kch_out_t push_word,
    output logic              m_valid,
    input  logic              m_ready,
    output kch_pkg::kch_out_t m_data,
    output logic [1:0]        count
);
    import kch_pkg::*;

    kch_out_t   slot_reg [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign m_valid = (count_reg != 2'd0);
    assign m_data  = slot_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign count   = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- src/kmer_count_histogram_core.sv -----
`timescale 1ns / 1ps
// K-mer count histogram core: top level with the table read-modify-write stage.
// Depends on kch_pkg, kch_table_ram, kch_front and kch_out_buf.

// After reset the core sweeps the 65536-entry count table to zero, one entry
// per cycle, and holds s_ready low for the whole sweep; word_length may be
// written meanwhile. It then takes one input word per cycle while s_ready is
// high. Each word reads the table in its accept cycle and writes it back in
// the next; a back-to-back hit on the same entry is forwarded, so the
// single-port-per-direction RAM sets the one-word-per-cycle rate. A
// read-and-clear result reaches m_ via s1_reg and the result buffer. s_ready
// then drops only while the two-entry buffer would overflow (results not taken).
module kmer_count_histogram_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [kch_pkg::WL_BITS-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  kch_pkg::kch_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output kch_pkg::kch_out_t           m_data
);
    import kch_pkg::*;

    logic [WL_BITS-1:0]  word_length_reg;
    logic [INDEX_BITS:0] clr_cnt_reg;
    logic                clearing;
    logic                accept;
    kch_ctrl_t           ctrl;
    kch_ctrl_t           s1_reg;
    logic                fwd_hit_reg, fwd_hit_next;
    count_t              fwd_data_reg;
    count_t              rd_data;
    count_t              operand;
    logic                s1_we;
    count_t              s1_wdata;
    logic                s1_res;
    logic                ram_we;
    index_t              ram_waddr;
    count_t              ram_wdata;
    kch_out_t            push_word;
    logic [1:0]          buf_count;
    logic [2:0]          occ_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_length_reg <= WL_BITS'(WORD_LENGTH_RST);
        end else if (cfg_valid) begin
            word_length_reg <= cfg_data;
        end
    end

    // clearing sweep; top bit set means done
    assign clearing = !clr_cnt_reg[INDEX_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clearing) begin
            clr_cnt_reg <= clr_cnt_reg + (INDEX_BITS+1)'(1);
        end
    end

    assign s1_res   = (s1_reg.op == OP_READ_CLEAR) || (s1_reg.op == OP_TOTAL);
    assign occ_next = {1'b0, buf_count} + {2'b00, s1_res} - {2'b00, m_valid && m_ready};
    assign s_ready  = !clearing && (occ_next < 3'd2);
    assign accept   = s_valid && s_ready;

    kch_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_word     (s_data),
        .word_length (word_length_reg),
        .ctrl        (ctrl)
    );

    // write-back stage
    assign operand  = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign s1_we    = (s1_reg.op == OP_INC) || (s1_reg.op == OP_READ_CLEAR);
    assign s1_wdata = (s1_reg.op == OP_INC) ? sat_inc(operand) : '0;

    assign ram_we    = clearing || s1_we;
    assign ram_waddr = clearing ? clr_cnt_reg[INDEX_BITS-1:0] : s1_reg.addr;
    assign ram_wdata = clearing ? '0 : s1_wdata;

    // write landing in the same cycle as a read of that entry
    assign fwd_hit_next = accept && s1_we && (s1_reg.addr == ctrl.addr);

    kch_table_ram #(
        .ADDR_BITS (INDEX_BITS),
        .DATA_BITS (COUNT_BITS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (accept),
        .rd_addr (ctrl.addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.op   <= OP_NONE;
            fwd_hit_reg <= 1'b0;
        end else begin
            s1_reg.op   <= accept ? ctrl.op : OP_NONE;
            fwd_hit_reg <= fwd_hit_next;
        end
        if (accept) begin
            s1_reg.addr  <= ctrl.addr;
            s1_reg.total <= ctrl.total;
        end
        fwd_data_reg <= s1_wdata;
    end

    always_comb begin
        push_word.is_total = (s1_reg.op == OP_TOTAL);
        push_word.value    = (s1_reg.op == OP_TOTAL) ? 32'(s1_reg.total) : 32'(operand);
    end

    kch_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_res),
        .push_word (push_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .count     (buf_count)
    );

`ifndef SYNTHESIS
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clearing |=> !clearing)
        else $error("table clear sweep restarted");

    a_fwd_source: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> $past(s1_we))
        else $error("forward hit without a table write in flight");

    a_buf_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_res |-> (buf_count != 2'd2))
        else $error("result buffer overflow");
`endif

endmodule
